@@ sv/matrix_multiply_defines.svh @@
// Assertion macros used by the matrix multiplier top level.
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mm_pkg.sv @@
// Types and fixed constants of the matrix multiplier.
package mm_pkg;

    // Width of a dimension register on the configuration port.
    localparam int CFG_W = 4;
    // Width of a configuration register index.
    localparam int CFG_IDX_W = 2;
    // Width of the full-precision dot product.
    localparam int ACC_W = 40;
    // Width of the row and column indexes on the result word.
    localparam int IDX_W = 3;
    // Result word: product, row, column, zero padding to whole bytes.
    localparam int OUT_TDATA_W = ((ACC_W + 2 * IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_TDATA_W - ACC_W - 2 * IDX_W;
    // Width of the operation selector on the input word.
    localparam int FUNC_W = 2;

    // Operation codes carried in tuser of the input channel.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } mm_func_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } mm_cfg_idx_t;

    // Tag that travels with each store read through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_inner;
        logic             last_all;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mm_tag_t;

    // Status of the multiply-accumulate pipeline.
    typedef struct packed {
        logic advance;
        logic busy;
    } mm_pipe_stat_t;

endpackage

@@ sv/matrix_multiply.sv @@
// Matrix multiplier C = A x B: top level with load control and configuration.
//
// Input words arrive on the s_axis channel: tuser selects the operation (load the
// next element of A, load the next element of B, or compute) and tdata carries a
// signed Q8.8 element. Loads fill A and B in row-major order, one word per cycle,
// and are dropped once a store holds MAX_DIM*MAX_DIM elements. A compute word
// streams the rows_a*cols_b dot products out of m_axis in row-major order as
// signed Q24.16 values with their row and column, tlast on the final one, and
// clears both load counters. The cfg channel writes rows_a, inner_dim and cols_b
// (index 0, 1, 2); 0 acts as 1 and values above MAX_DIM act as MAX_DIM.
// The speed of a run is set by the single multiply-accumulate unit, fed by one
// read port of each store; each read passes the store read register and the
// multiply and accumulate stages before reaching the result register.
// No input word is accepted until the run has left the pipeline.
// Reset clears the load counters and sets each dimension to 8 (or MAX_DIM if
// smaller); store contents are undefined until loaded. While the receiver holds
// tready low, the result register keeps its word and the pipeline runs on until
// the next finished sum reaches its last stage, then freezes.
`include "matrix_multiply_defines.svh"

module matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input words.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: value [DATA_WIDTH-1:0], zero padding above.
    input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    // tuser: func [1:0].
    input  logic [mm_pkg::FUNC_W-1:0]           s_axis_tuser,
    // Result words.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: product_value [39:0], row_index [42:40], col_index [45:43], zeros.
    output logic [mm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]            cfg_data
);
    import mm_pkg::*;

    localparam int CAP       = MAX_DIM * MAX_DIM;
    localparam int AW        = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CW        = $clog2(CAP + 1);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int RESET_DIM = (MAX_DIM < 8) ? MAX_DIM : 8;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    a_count_reg, a_count_next;
    logic [CW-1:0]    b_count_reg, b_count_next;
    logic [DIM_W-1:0] dim_m_reg, dim_m_next;
    logic [DIM_W-1:0] dim_n_reg, dim_n_next;
    logic [DIM_W-1:0] dim_k_reg, dim_k_next;

    logic                  in_accept;
    logic                  cfg_accept;
    mm_func_t              in_func;
    logic [DATA_WIDTH-1:0] in_value;
    logic                  a_we, b_we;
    logic                  start;
    logic                  rd_en;
    logic [AW-1:0]         a_raddr, b_raddr;
    logic [DATA_WIDTH-1:0] a_q, b_q;
    mm_tag_t               tag;
    logic                  gen_busy;
    mm_pipe_stat_t         stat;

    // Limits a written dimension to the range 1 to MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(d);
        end
        return r;
    endfunction

    // Handshakes and input word decode.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_accept    = cfg_valid && cfg_ready;
    assign in_func       = mm_func_t'(s_axis_tuser);
    assign in_value      = s_axis_tdata[DATA_WIDTH-1:0];

    assign a_we  = in_accept && (in_func == FUNC_LOAD_A) && (a_count_reg < CW'(CAP));
    assign b_we  = in_accept && (in_func == FUNC_LOAD_B) && (b_count_reg < CW'(CAP));
    assign start = in_accept && (in_func == FUNC_COMPUTE);

    // Control state, load counters and dimension registers.
    always_comb
    begin
        state_next   = state_reg;
        a_count_next = a_count_reg;
        b_count_next = b_count_reg;
        dim_m_next   = dim_m_reg;
        dim_n_next   = dim_n_reg;
        dim_k_next   = dim_k_reg;
        if (cfg_accept)
        begin
            case (cfg_index)
                CFG_ROWS_A:    dim_m_next = clamp_dim(cfg_data);
                CFG_INNER_DIM: dim_n_next = clamp_dim(cfg_data);
                CFG_COLS_B:    dim_k_next = clamp_dim(cfg_data);
                default:       ;
            endcase
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (a_we)
                begin
                    a_count_next = a_count_reg + CW'(1);
                end
                if (b_we)
                begin
                    b_count_next = b_count_reg + CW'(1);
                end
                if (start)
                begin
                    a_count_next = '0;
                    b_count_next = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!gen_busy && !stat.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            a_count_reg <= '0;
            b_count_reg <= '0;
            dim_m_reg   <= DIM_W'(RESET_DIM);
            dim_n_reg   <= DIM_W'(RESET_DIM);
            dim_k_reg   <= DIM_W'(RESET_DIM);
        end
        else
        begin
            state_reg   <= state_next;
            a_count_reg <= a_count_next;
            b_count_reg <= b_count_next;
            dim_m_reg   <= dim_m_next;
            dim_n_reg   <= dim_n_next;
            dim_k_reg   <= dim_k_next;
        end
    end

    // Element stores.
    mm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAP)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_count_reg[AW-1:0]),
        .wdata (in_value),
        .re    (rd_en),
        .raddr (a_raddr),
        .rdata (a_q)
    );

    mm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAP)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_count_reg[AW-1:0]),
        .wdata (in_value),
        .re    (rd_en),
        .raddr (b_raddr),
        .rdata (b_q)
    );

    // Loop sequencer.
    mm_addr_gen #(
        .MAX_DIM (MAX_DIM)
    ) u_addr_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .advance (stat.advance),
        .dim_m   (dim_m_reg),
        .dim_n   (dim_n_reg),
        .dim_k   (dim_k_reg),
        .rd_en   (rd_en),
        .a_addr  (a_raddr),
        .b_addr  (b_raddr),
        .tag     (tag),
        .busy    (gen_busy)
    );

    // Multiply-accumulate and result register.
    mm_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag_in        (tag),
        .a_q           (a_q),
        .b_q           (b_q),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A compute word leaves both load counters at zero.
    `MM_ASSERT_NEXT(a_start_clears, clk, rst_n, start, (a_count_reg == '0) && (b_count_reg == '0), "load counters not cleared by compute")
    // The sequencer only runs during a compute run.
    `MM_ASSERT_NOW(a_gen_in_run, clk, rst_n, gen_busy, state_reg == ST_RUN, "sequencer active outside a run")
    // The pipeline stalls only behind a waiting result.
    `MM_ASSERT_NOW(a_stall_has_result, clk, rst_n, !stat.advance, m_axis_tvalid && !m_axis_tready, "pipeline stalled without a pending result")
    // No store is written while reads of a run are under way.
    `MM_ASSERT_NOW(a_no_load_in_run, clk, rst_n, a_we || b_we, !gen_busy && !stat.busy, "store written during a run")

endmodule

@@ sv/mm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data register holds while the read is not enabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/mm_addr_gen.sv @@
// Sequencer that walks the row, column and inner loops and issues store reads.
module mm_addr_gen #(
    parameter int MAX_DIM = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  advance,
    input  logic [$clog2(MAX_DIM+1)-1:0] dim_m,
    input  logic [$clog2(MAX_DIM+1)-1:0] dim_n,
    input  logic [$clog2(MAX_DIM+1)-1:0] dim_k,
    output logic                  rd_en,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] a_addr,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] b_addr,
    output mm_pkg::mm_tag_t       tag,
    output logic                  busy
);
    import mm_pkg::*;

    localparam int CAP   = MAX_DIM * MAX_DIM;
    localparam int AW    = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CW    = $clog2(CAP + 1);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic          active_reg, active_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] h_reg, h_next;
    logic [CW-1:0] a_base_reg, a_base_next;
    logic [CW-1:0] b_ptr_reg, b_ptr_next;
    mm_tag_t       tag_reg, tag_next;

    logic          h_last, j_last, i_last;
    logic          issue;
    logic [CW-1:0] a_sum;
    logic [DIM_W-1:0] m_m1, n_m1, k_m1;
    mm_tag_t       tag_issue;

    // Loop end detection.
    assign m_m1   = dim_m - DIM_W'(1);
    assign n_m1   = dim_n - DIM_W'(1);
    assign k_m1   = dim_k - DIM_W'(1);
    assign h_last = (h_reg == IW'(n_m1));
    assign j_last = (j_reg == IW'(k_m1));
    assign i_last = (i_reg == IW'(m_m1));
    assign issue  = active_reg && advance;

    // A is read at i*n+h, B at h*k+j.
    assign a_sum  = a_base_reg + CW'(h_reg);
    assign a_addr = a_sum[AW-1:0];
    assign b_addr = b_ptr_reg[AW-1:0];
    assign rd_en  = issue;

    // Tag of the read issued in this cycle.
    always_comb
    begin
        tag_issue.valid      = active_reg;
        tag_issue.first      = (h_reg == '0);
        tag_issue.last_inner = h_last;
        tag_issue.last_all   = h_last && j_last && i_last;
        tag_issue.row        = IDX_W'(i_reg);
        tag_issue.col        = IDX_W'(j_reg);
    end

    // Loop counters.
    always_comb
    begin
        active_next = active_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        h_next      = h_reg;
        a_base_next = a_base_reg;
        b_ptr_next  = b_ptr_reg;
        tag_next    = tag_reg;
        if (advance)
        begin
            tag_next = tag_issue;
        end
        if (start)
        begin
            active_next = 1'b1;
            i_next      = '0;
            j_next      = '0;
            h_next      = '0;
            a_base_next = '0;
            b_ptr_next  = '0;
        end
        else if (issue)
        begin
            if (h_last)
            begin
                h_next = '0;
                if (j_last)
                begin
                    j_next      = '0;
                    b_ptr_next  = '0;
                    a_base_next = a_base_reg + CW'(dim_n);
                    if (i_last)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg + IW'(1);
                    end
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    b_ptr_next = CW'(j_reg) + CW'(1);
                end
            end
            else
            begin
                h_next     = h_reg + IW'(1);
                b_ptr_next = b_ptr_reg + CW'(dim_k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            tag_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            tag_reg    <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        h_reg      <= h_next;
        a_base_reg <= a_base_next;
        b_ptr_reg  <= b_ptr_next;
    end

    assign tag  = tag_reg;
    assign busy = active_reg || tag_reg.valid;

endmodule

@@ sv/mm_mac.sv @@
// Multiply-accumulate pipeline with the result output register.
module mm_mac #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mm_pkg::mm_tag_t                    tag_in,
    input  logic [DATA_WIDTH-1:0]              a_q,
    input  logic [DATA_WIDTH-1:0]              b_q,
    output mm_pkg::mm_pipe_stat_t              stat,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);
    import mm_pkg::*;

    mm_tag_t                      s2_tag_reg, s2_tag_next;
    mm_tag_t                      s3_tag_reg, s3_tag_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]      prod_reg, prod_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic [ACC_W-1:0]             out_value_reg, out_value_next;
    logic [IDX_W-1:0]             out_row_reg, out_row_next;
    logic [IDX_W-1:0]             out_col_reg, out_col_next;
    logic                         out_last_reg, out_last_next;

    logic signed [2*DATA_WIDTH-1:0] mul_full;
    logic                           s3_done;
    logic                           advance;

    // Full signed product of the two elements.
    assign mul_full = $signed(a_q) * $signed(b_q);

    // The pipeline freezes while a finished sum waits for a full output.
    assign s3_done = s3_tag_reg.valid && s3_tag_reg.last_inner;
    assign advance = !(s3_done && out_valid_reg && !m_axis_tready);

    always_comb
    begin
        s2_tag_next    = s2_tag_reg;
        s3_tag_next    = s3_tag_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            // Multiply stage.
            s2_tag_next = tag_in;
            prod_next   = ACC_W'(mul_full);
            // Accumulate stage.
            s3_tag_next = s2_tag_reg;
            if (s2_tag_reg.valid)
            begin
                acc_next = s2_tag_reg.first ? prod_reg : acc_reg + prod_reg;
            end
            // Finished sum moves to the output register.
            if (s3_done)
            begin
                out_valid_next = 1'b1;
                out_value_next = acc_reg;
                out_row_next   = s3_tag_reg.row;
                out_col_next   = s3_tag_reg.col;
                out_last_next  = s3_tag_reg.last_all;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg    <= '0;
            s3_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_tag_reg    <= s2_tag_next;
            s3_tag_reg    <= s3_tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        out_value_reg <= out_value_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

    assign stat.advance  = advance;
    assign stat.busy     = s2_tag_reg.valid || s3_tag_reg.valid;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_col_reg, out_row_reg, out_value_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
